/* sv/scc_pkg.sv */
`timescale 1ns / 1ps
package scc_pkg;

  // item modes
  localparam logic [1:0] MODE_CLEAR   = 2'd0;
  localparam logic [1:0] MODE_ADD     = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;
  localparam logic [1:0] MODE_QUERY   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_NOTCOMP = 2'd3;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_ADD_RD,
    OP_ADD_WR,
    OP_ADD_LINK,
    OP_INIT_FWD,
    OP_INIT_REV,
    OP_PICK,
    OP_START,
    OP_HEAD,
    OP_STEP,
    OP_EDGE,
    OP_POPLD,
    OP_DONE,
    OP_RESP
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_WR,
    S_ADD_LINK,
    S_CHECK,
    S_PICK,
    S_START,
    S_HEAD,
    S_STEP,
    S_EDGE,
    S_POPLD,
    S_RESP
  } state_t;

  // datapath status back to the controller
  typedef struct packed {
    logic [1:0] mode;
    logic       err;
    logic       more;
    logic       rev;
    logic       cand_seen;
    logic       cur_none;
    logic       sp_gt1;
    logic       push;
    logic       out_free;
  } sts_t;

endpackage

/* sv/strongly_connected_components.sv */
`timescale 1ns / 1ps
// Kosaraju strongly connected components over a loaded directed graph.
// Input channel (in_valid / in_stall) carries one item per transaction: mode
// selects clear graph, add edge (from_vertex -> to_vertex), compute, or query
// of query_vertex. Every item returns exactly one result on the output channel
// (out_valid / out_stall): component_id, component_count and status.
// The config channel (cfg_valid / cfg_ready) writes vertex_count; it is always
// ready and must only be written while no item is in flight.
// Items are handled one at a time. Clear and query are decoded and go straight
// to the response state; a valid add edge first reads the list tails and head
// flags, then writes the edge and links it into both lists. Compute runs two
// depth-first passes through a stack memory, reading each edge from the edge
// store before it is examined and pushing each unseen target onto the stack.
// Reset empties the graph, zeroes the counts, sets vertex_count to 256 and
// invalidates labels; no clearing pass is needed. A stalled result is held in
// the output register; one more item can be accepted and worked on, but its
// result waits until the held one is taken, and input stalls meanwhile.
module strongly_connected_components import scc_pkg::*; #(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_EDGES    = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] from_vertex,
  input  logic [7:0] to_vertex,
  input  logic [7:0] query_vertex,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] component_id,
  output logic [8:0] component_count,
  output logic [1:0] status
);

  op_t  op;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .op       (op)
  );

  // graph stores and walk datapath
  scc_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .sts             (sts),
    .mode            (mode),
    .from_vertex     (from_vertex),
    .to_vertex       (to_vertex),
    .query_vertex    (query_vertex),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .component_id    (component_id),
    .component_count (component_count),
    .status          (status)
  );

endmodule

/* sv/scc_ctrl.sv */
`timescale 1ns / 1ps
module scc_ctrl import scc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output op_t  op
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath operation
  always_comb begin
    state_next = state;
    op = OP_NONE;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.mode)
          MODE_CLEAR: begin
            op = OP_CLEAR;
            state_next = S_RESP;
          end
          MODE_ADD: begin
            if (sts.err) begin
              state_next = S_RESP;
            end else begin
              op = OP_ADD_RD;
              state_next = S_ADD_WR;
            end
          end
          MODE_COMPUTE: begin
            op = OP_INIT_FWD;
            state_next = S_CHECK;
          end
          default: state_next = S_RESP;
        endcase
      end
      S_ADD_WR: begin
        op = OP_ADD_WR;
        state_next = S_ADD_LINK;
      end
      S_ADD_LINK: begin
        op = OP_ADD_LINK;
        state_next = S_RESP;
      end
      S_CHECK: begin
        if (sts.more) begin
          state_next = sts.rev ? S_PICK : S_START;
        end else if (!sts.rev) begin
          op = OP_INIT_REV;
        end else begin
          op = OP_DONE;
          state_next = S_RESP;
        end
      end
      S_PICK: begin
        op = OP_PICK;
        state_next = S_START;
      end
      S_START: begin
        op = OP_START;
        state_next = sts.cand_seen ? S_CHECK : S_HEAD;
      end
      S_HEAD: begin
        op = OP_HEAD;
        state_next = S_STEP;
      end
      S_STEP: begin
        op = OP_STEP;
        if (!sts.cur_none) begin
          state_next = S_EDGE;
        end else if (sts.sp_gt1) begin
          state_next = S_POPLD;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_EDGE: begin
        op = OP_EDGE;
        state_next = sts.push ? S_HEAD : S_STEP;
      end
      S_POPLD: begin
        op = OP_POPLD;
        state_next = S_STEP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          op = OP_RESP;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* sv/scc_dp.sv */
`timescale 1ns / 1ps
module scc_dp import scc_pkg::*; #(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_EDGES    = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  op_t        op,
  output sts_t       sts,
  input  logic [1:0] mode,
  input  logic [7:0] from_vertex,
  input  logic [7:0] to_vertex,
  input  logic [7:0] query_vertex,
  input  logic       cfg_valid,
  input  logic [8:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] component_id,
  output logic [8:0] component_count,
  output logic [1:0] status
);

  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam logic [EW-1:0] EDGE_NONE = EW'(MAX_EDGES);

  // adjacency stores
  logic [VAW-1:0] fwd_target [MAX_EDGES];
  logic [EW-1:0]  fwd_nxt    [MAX_EDGES];
  logic [VAW-1:0] rev_target [MAX_EDGES];
  logic [EW-1:0]  rev_nxt    [MAX_EDGES];
  logic [EAW-1:0] fwd_head   [MAX_VERTICES];
  logic [EAW-1:0] rev_head   [MAX_VERTICES];
  logic [EAW-1:0] fwd_tail   [MAX_VERTICES];
  logic [EAW-1:0] rev_tail   [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] fwd_hvld, rev_hvld;

  // walk stores
  logic [MAX_VERTICES-1:0] seen;
  logic [VAW-1:0] finish_order [MAX_VERTICES];
  logic [VAW-1:0] stk_v        [MAX_VERTICES];
  logic [EW-1:0]  stk_c        [MAX_VERTICES];
  logic [VAW-1:0] label_store  [MAX_VERTICES];

  // control and scalar registers
  logic [8:0]    vertex_count;
  logic [EW-1:0] edge_total;
  logic [NW-1:0] group_total;
  logic          labels_valid;
  logic [1:0]    mode_q;
  logic [7:0]    from_q, to_q;
  logic [1:0]    resp_status;
  logic          rev;
  logic [NW-1:0] idx, k, finished, sp;
  logic [VAW-1:0] top_v;
  logic [EW-1:0]  top_cur;

  // read registers
  logic [EAW-1:0] ftail_rd, rtail_rd;
  logic           fhv_l, rhv_l;
  logic [EAW-1:0] fhead_rd, rhead_rd;
  logic           fhv_rd, rhv_rd;
  logic [VAW-1:0] ftgt_rd, rtgt_rd;
  logic [EW-1:0]  fnxt_rd, rnxt_rd;
  logic [VAW-1:0] fin_rd, stkv_rd, label_rd;
  logic [EW-1:0]  stkc_rd;

  logic [NW-1:0]  n;
  logic [EAW-1:0] slot;
  logic [VAW-1:0] cand, tgt, head_addr;
  logic [EW-1:0]  nc;
  logic           push, cur_none, out_free;

  // active vertex count and walk decode
  assign n = (32'(vertex_count) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vertex_count);
  assign slot = edge_total[EAW-1:0];
  assign cand = rev ? fin_rd : VAW'(idx);
  assign tgt = rev ? rtgt_rd : ftgt_rd;
  assign nc = rev ? rnxt_rd : fnxt_rd;
  assign cur_none = (top_cur == EDGE_NONE);
  assign push = (32'(tgt) < 32'(n)) && !seen[tgt] && (32'(sp) < MAX_VERTICES);
  assign head_addr = (op == OP_EDGE) ? tgt : cand;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sts.mode = mode_q;
    sts.err = (resp_status != ST_OK);
    sts.more = rev ? (k != '0) : (32'(idx) < 32'(n));
    sts.rev = rev;
    sts.cand_seen = seen[cand];
    sts.cur_none = cur_none;
    sts.sp_gt1 = (32'(sp) > 1);
    sts.push = push;
    sts.out_free = out_free;
  end

  // forward and reverse edge lists
  always_ff @(posedge clk) begin
    if (op == OP_ADD_RD) begin
      ftail_rd <= fwd_tail[VAW'(from_q)];
      rtail_rd <= rev_tail[VAW'(to_q)];
    end
    if (op == OP_ADD_WR) begin
      fwd_target[slot] <= VAW'(to_q);
      rev_target[slot] <= VAW'(from_q);
      fwd_tail[VAW'(from_q)] <= slot;
      rev_tail[VAW'(to_q)] <= slot;
      if (!fhv_l) begin
        fwd_head[VAW'(from_q)] <= slot;
      end
      if (!rhv_l) begin
        rev_head[VAW'(to_q)] <= slot;
      end
    end
    if (op == OP_ADD_WR) begin
      fwd_nxt[slot] <= EDGE_NONE;
    end else if (op == OP_ADD_LINK && fhv_l) begin
      fwd_nxt[ftail_rd] <= EW'(slot);
    end
    if (op == OP_ADD_WR) begin
      rev_nxt[slot] <= EDGE_NONE;
    end else if (op == OP_ADD_LINK && rhv_l) begin
      rev_nxt[rtail_rd] <= EW'(slot);
    end
    if (op == OP_START || op == OP_EDGE) begin
      fhead_rd <= fwd_head[head_addr];
      rhead_rd <= rev_head[head_addr];
      fhv_rd <= fwd_hvld[head_addr];
      rhv_rd <= rev_hvld[head_addr];
    end
    if (op == OP_STEP) begin
      ftgt_rd <= fwd_target[top_cur[EAW-1:0]];
      fnxt_rd <= fwd_nxt[top_cur[EAW-1:0]];
      rtgt_rd <= rev_target[top_cur[EAW-1:0]];
      rnxt_rd <= rev_nxt[top_cur[EAW-1:0]];
    end
  end

  // finish order, walk stack and labels
  always_ff @(posedge clk) begin
    if (op == OP_STEP && cur_none) begin
      if (!rev && 32'(finished) < MAX_VERTICES) begin
        finish_order[VAW'(finished)] <= top_v;
      end
      if (rev) begin
        label_store[top_v] <= VAW'(group_total);
      end
      if (32'(sp) > 1) begin
        stkv_rd <= stk_v[VAW'(sp - NW'(2))];
        stkc_rd <= stk_c[VAW'(sp - NW'(2))];
      end
    end
    if (op == OP_EDGE && push) begin
      stk_v[VAW'(sp - NW'(1))] <= top_v;
      stk_c[VAW'(sp - NW'(1))] <= nc;
    end
    if (op == OP_PICK) begin
      fin_rd <= finish_order[VAW'(k - NW'(1))];
    end
    if (op == OP_LOAD) begin
      label_rd <= label_store[VAW'(query_vertex)];
    end
  end

  // item, walk payload and result registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        mode_q <= mode;
        from_q <= from_vertex;
        to_q <= to_vertex;
      end
      OP_ADD_RD: begin
        fhv_l <= fwd_hvld[VAW'(from_q)];
        rhv_l <= rev_hvld[VAW'(to_q)];
      end
      OP_START: begin
        if (!seen[cand]) begin
          top_v <= cand;
        end
      end
      OP_HEAD: begin
        if (rev) begin
          top_cur <= rhv_rd ? EW'(rhead_rd) : EDGE_NONE;
        end else begin
          top_cur <= fhv_rd ? EW'(fhead_rd) : EDGE_NONE;
        end
      end
      OP_EDGE: begin
        top_cur <= nc;
        if (push) begin
          top_v <= tgt;
        end
      end
      OP_POPLD: begin
        top_v <= stkv_rd;
        top_cur <= stkc_rd;
      end
      OP_RESP: begin
        component_id <= (mode_q == MODE_QUERY && resp_status == ST_OK) ?
                        8'(label_rd) : 8'd0;
        component_count <= 9'(group_total);
        status <= resp_status;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 9'd256;
      edge_total <= '0;
      group_total <= '0;
      labels_valid <= 1'b0;
      fwd_hvld <= '0;
      rev_hvld <= '0;
      seen <= '0;
      rev <= 1'b0;
      idx <= '0;
      k <= '0;
      finished <= '0;
      sp <= '0;
      resp_status <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        vertex_count <= cfg_data;
        labels_valid <= 1'b0;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_LOAD: begin
          resp_status <= ST_OK;
          if (mode == MODE_ADD) begin
            if (32'(from_vertex) >= 32'(n) || 32'(to_vertex) >= 32'(n)) begin
              resp_status <= ST_RANGE;
            end else if (32'(edge_total) >= MAX_EDGES) begin
              resp_status <= ST_FULL;
            end
          end else if (mode == MODE_QUERY) begin
            if (32'(query_vertex) >= 32'(n)) begin
              resp_status <= ST_RANGE;
            end else if (!labels_valid) begin
              resp_status <= ST_NOTCOMP;
            end
          end
        end
        OP_CLEAR: begin
          fwd_hvld <= '0;
          rev_hvld <= '0;
          edge_total <= '0;
          group_total <= '0;
          labels_valid <= 1'b0;
        end
        OP_ADD_WR: begin
          fwd_hvld[VAW'(from_q)] <= 1'b1;
          rev_hvld[VAW'(to_q)] <= 1'b1;
        end
        OP_ADD_LINK: begin
          edge_total <= edge_total + EW'(1);
          labels_valid <= 1'b0;
        end
        OP_INIT_FWD: begin
          seen <= '0;
          rev <= 1'b0;
          idx <= '0;
          finished <= '0;
        end
        OP_INIT_REV: begin
          seen <= '0;
          rev <= 1'b1;
          group_total <= '0;
          k <= finished;
        end
        OP_START: begin
          if (seen[cand]) begin
            if (rev) begin
              k <= k - NW'(1);
            end else begin
              idx <= idx + NW'(1);
            end
          end else begin
            seen[cand] <= 1'b1;
            sp <= NW'(1);
          end
        end
        OP_STEP: begin
          if (cur_none) begin
            sp <= sp - NW'(1);
            if (!rev && 32'(finished) < MAX_VERTICES) begin
              finished <= finished + NW'(1);
            end
            // walk finished: count a component in the reverse pass and move to next start vertex
            if (32'(sp) <= 1) begin
              if (rev) begin
                group_total <= group_total + NW'(1);
                k <= k - NW'(1);
              end else begin
                idx <= idx + NW'(1);
              end
            end
          end
        end
        OP_EDGE: begin
          if (push) begin
            seen[tgt] <= 1'b1;
            sp <= sp + NW'(1);
          end
        end
        OP_DONE: begin
          labels_valid <= 1'b1;
        end
        OP_RESP: begin
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
